// ===== rtl/mcf_pkg.sv =====
`timescale 1ns / 1ps
// mcf_pkg: shared types and constants of the multichannel comb filter
// no dependencies

package mcf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 15;
    localparam int DLY_W      = 11;
    localparam int CHAN_W     = 1;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [1:0] {
        REG_IIR_MODE = 2'd0,
        REG_GAIN     = 2'd1,
        REG_DELAY    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic                     iir_mode;
        logic signed [GAIN_W-1:0] gain;
        logic [DLY_W-1:0]         delay;
        logic                     delay_wr;
    } cfg_t;

    typedef struct packed {
        logic [CHAN_W-1:0]          ch;
        logic signed [SAMPLE_W-1:0] data;
        logic                       last;
    } out_item_t;

endpackage

// ===== rtl/multichannel_comb_filter.sv =====
`timescale 1ns / 1ps
// multichannel_comb_filter: per-channel fir/iir comb over one delay memory
// depends on mcf_pkg and mcf_apb_regs
//
//  port group | direction | contents
//  s_*        | in        | tuser channel, tdata sample, tlast last_of_block
//  m_*        | out       | tuser out_channel, tdata filtered, tlast out_last_of_block
//  apb        | in/out    | iir_mode at 0x0, gain at 0x4, delay_frames at 0x8
//
// one sample per cycle while s_tready is high; a result passes the stage 1 and stage 2 registers and the output queue
// after reset a sweep over all CHANNELS*MAX_DELAY entries zeroes the delay memory,
// s_tready stays low until it ends
// in iir mode a sample whose delayed entry is written by the sample just
// before it waits while that sample is in stage 1; that result leaves the adder a stage after
// the multiply needs it
// the four-entry output queue keeps the input open while results wait

module multichannel_comb_filter
    import mcf_pkg::*;
#(
    parameter int CHANNELS  = 2,
    parameter int MAX_DELAY = 1024
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [SAMPLE_W-1:0]        s_tdata,   // [15:0] sample
    input  logic [CHAN_W-1:0]          s_tuser,   // [0] channel
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [SAMPLE_W-1:0]        m_tdata,   // [15:0] filtered
    output logic [CHAN_W-1:0]          m_tuser,   // [0] out_channel
    output logic                       m_tlast,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int DEPTH  = CHANNELS * MAX_DELAY;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PTR_W  = $clog2(MAX_DELAY);
    localparam int SUM_W  = PTR_W + 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_W = SAMPLE_W + GAIN_W;
    localparam int ACC_W  = PROD_W + 1;

    cfg_t cfg;

    mcf_apb_regs #(
        .MAX_DELAY (MAX_DELAY)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // clearing sweep
    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    // per-channel write pointers
    logic [PTR_W-1:0]  wptr_reg [CHANNELS];

    // stage 0
    logic              accept0;
    logic              inr0;
    logic [CH_W-1:0]   ch_idx0;
    logic [PTR_W-1:0]  wp0;
    logic [PTR_W-1:0]  rp0;
    logic [PTR_W-1:0]  wp0_next;
    logic [SUM_W-1:0]  sum0;
    logic [ADDR_W-1:0] base0;
    logic [ADDR_W-1:0] raddr0;
    logic [ADDR_W-1:0] waddr0;
    logic              hazard0;
    logic              space0;

    // stage 1
    logic                       v1_reg;
    logic                       inr1_reg;
    logic [CHAN_W-1:0]          ch1_reg;
    logic signed [SAMPLE_W-1:0] x1_reg;
    logic                       last1_reg;
    logic [ADDR_W-1:0]          raddr1_reg;
    logic [ADDR_W-1:0]          waddr1_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic signed [SAMPLE_W-1:0] delayed1;
    logic signed [PROD_W-1:0]   prod_next;

    // stage 2
    logic                       v2_reg;
    logic                       inr2_reg;
    logic [CHAN_W-1:0]          ch2_reg;
    logic signed [SAMPLE_W-1:0] x2_reg;
    logic                       last2_reg;
    logic [ADDR_W-1:0]          waddr2_reg;
    logic signed [PROD_W-1:0]   prod2_reg;
    logic signed [ACC_W-1:0]    acc2;
    logic [ACC_W-GAIN_FRAC-1:0] shifted2;
    logic signed [SAMPLE_W-1:0] y2;

    // memory write port and bypass of the latest write
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic signed [SAMPLE_W-1:0] mem_wdata;
    logic                       item_we;
    logic                       fw_v_reg;
    logic [ADDR_W-1:0]          fw_addr_reg;
    logic signed [SAMPLE_W-1:0] fw_data_reg;

    logic signed [SAMPLE_W-1:0] delay_mem [DEPTH];

    // output queue
    out_item_t                 fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]     fifo_wr_reg;
    logic [FIFO_PTR_W-1:0]     fifo_rd_reg;
    logic [FIFO_CNT_W-1:0]     fifo_cnt_reg;
    logic [FIFO_CNT_W-1:0]     occupancy;
    logic                      push;
    logic                      pop;
    out_item_t                 head;

    // stage 0: address generation and hazard check
    always_comb
    begin
        inr0    = 32'(s_tuser) < CHANNELS;
        ch_idx0 = CH_W'(s_tuser);
        wp0     = wptr_reg[ch_idx0];
        sum0    = SUM_W'(wp0) + SUM_W'(MAX_DELAY) - SUM_W'(cfg.delay);
        if (sum0 >= SUM_W'(MAX_DELAY))
        begin
            rp0 = PTR_W'(sum0 - SUM_W'(MAX_DELAY));
        end
        else
        begin
            rp0 = PTR_W'(sum0);
        end
        wp0_next = (wp0 == PTR_W'(MAX_DELAY - 1)) ? '0 : wp0 + PTR_W'(1);
        base0    = ADDR_W'(32'(ch_idx0) * MAX_DELAY);
        raddr0   = base0 + ADDR_W'(rp0);
        waddr0   = base0 + ADDR_W'(wp0);
        hazard0  = cfg.iir_mode && v1_reg && inr1_reg && inr0 && (raddr0 == waddr1_reg);
    end

    assign occupancy = fifo_cnt_reg + FIFO_CNT_W'(v1_reg) + FIFO_CNT_W'(v2_reg);
    assign space0    = occupancy < FIFO_CNT_W'(FIFO_DEPTH);
    assign s_tready  = !clr_active_reg && space0 && !hazard0;
    assign accept0   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                wptr_reg[i] <= '0;
            end
        end
        else if (cfg.delay_wr)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                wptr_reg[i] <= '0;
            end
        end
        else if (accept0 && inr0)
        begin
            wptr_reg[ch_idx0] <= wp0_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // stage 1: pick the newest copy of the delayed sample, multiply
    always_comb
    begin
        if (!cfg.iir_mode && v2_reg && inr2_reg && (waddr2_reg == raddr1_reg))
        begin
            delayed1 = x2_reg;
        end
        else if (fw_v_reg && (fw_addr_reg == raddr1_reg))
        begin
            delayed1 = fw_data_reg;
        end
        else
        begin
            delayed1 = rd_data_reg;
        end
        if (inr1_reg)
        begin
            prod_next = cfg.gain * delayed1;
        end
        else
        begin
            prod_next = '0;
        end
    end

    // stage 2: align, floor shift, saturate
    always_comb
    begin
        acc2     = {{(ACC_W - SAMPLE_W - GAIN_FRAC){x2_reg[SAMPLE_W-1]}}, x2_reg,
                    {GAIN_FRAC{1'b0}}}
                   + ACC_W'(prod2_reg);
        shifted2 = acc2[ACC_W-1:GAIN_FRAC];
        if (shifted2[ACC_W-GAIN_FRAC-1:SAMPLE_W-1] == '0
            || shifted2[ACC_W-GAIN_FRAC-1:SAMPLE_W-1] == '1)
        begin
            y2 = shifted2[SAMPLE_W-1:0];
        end
        else if (shifted2[ACC_W-GAIN_FRAC-1])
        begin
            y2 = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            y2 = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    assign item_we   = v2_reg && inr2_reg;
    assign mem_we    = clr_active_reg || item_we;
    assign mem_waddr = clr_active_reg ? clr_cnt_reg : waddr2_reg;
    assign mem_wdata = clr_active_reg ? '0 : (cfg.iir_mode ? y2 : x2_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            delay_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= delay_mem[raddr0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            fw_v_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept0;
            v2_reg   <= v1_reg;
            fw_v_reg <= item_we;
        end
    end

    always_ff @(posedge clk)
    begin
        inr1_reg    <= inr0;
        ch1_reg     <= s_tuser;
        x1_reg      <= s_tdata;
        last1_reg   <= s_tlast;
        raddr1_reg  <= raddr0;
        waddr1_reg  <= waddr0;
        inr2_reg    <= inr1_reg;
        ch2_reg     <= ch1_reg;
        x2_reg      <= x1_reg;
        last2_reg   <= last1_reg;
        waddr2_reg  <= waddr1_reg;
        prod2_reg   <= prod_next;
        fw_addr_reg <= waddr2_reg;
        fw_data_reg <= mem_wdata;
    end

    // output queue
    assign push = v2_reg;
    assign pop  = m_tvalid && m_tready;
    assign head = fifo_mem[fifo_rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[fifo_wr_reg] <= '{ch: ch2_reg, data: y2, last: last2_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_wr_reg  <= '0;
            fifo_rd_reg  <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                fifo_wr_reg <= fifo_wr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                fifo_rd_reg <= fifo_rd_reg + FIFO_PTR_W'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        end
    end

    assign m_tvalid = fifo_cnt_reg != '0;
    assign m_tdata  = head.data;
    assign m_tuser  = head.ch;
    assign m_tlast  = head.last;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (!s_tready && !v1_reg && !v2_reg && fifo_cnt_reg == '0))
        else $error("transfer or pipeline activity during memory clear");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("output queue credit exceeded");

    a_iir_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.iir_mode && v1_reg && v2_reg && inr1_reg && inr2_reg)
        |-> (raddr1_reg != waddr2_reg))
        else $error("iir read overlaps a pending write");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |=> (fifo_cnt_reg != '0))
        else $error("finished sample not queued");
`endif

endmodule

// ===== rtl/mcf_apb_regs.sv =====
`timescale 1ns / 1ps
// mcf_apb_regs: apb register file for mode, gain and delay
// depends on mcf_pkg

module mcf_apb_regs
    import mcf_pkg::*;
#(
    parameter int MAX_DELAY = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic                     iir_mode_reg;
    logic signed [GAIN_W-1:0] gain_reg;
    logic [DLY_W-1:0]         delay_reg;
    logic [DLY_W-1:0]         delay_next;
    logic                     wr_en;
    reg_idx_t                 idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[3:2]);

    // clamp delay into 1..MAX_DELAY
    always_comb
    begin
        delay_next = pwdata[DLY_W-1:0];
        if (delay_next == '0)
        begin
            delay_next = DLY_W'(1);
        end
        else if (32'(delay_next) > MAX_DELAY)
        begin
            delay_next = DLY_W'(MAX_DELAY);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iir_mode_reg <= 1'b0;
            gain_reg     <= '0;
            delay_reg    <= DLY_W'(1);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_IIR_MODE: iir_mode_reg <= pwdata[0];
                REG_GAIN:     gain_reg     <= pwdata[GAIN_W-1:0];
                REG_DELAY:    delay_reg    <= delay_next;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_IIR_MODE: prdata = APB_DATA_W'(iir_mode_reg);
            REG_GAIN:     prdata = APB_DATA_W'($unsigned(gain_reg));
            REG_DELAY:    prdata = APB_DATA_W'(delay_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.iir_mode = iir_mode_reg;
    assign cfg.gain     = gain_reg;
    assign cfg.delay    = delay_reg;
    assign cfg.delay_wr = wr_en && (idx == REG_DELAY);

endmodule
